FILE: rtl/dtq_pkg.sv
// Package for the deadline timer queue: sizes, result kinds and the
// controller/datapath command and status structs. No dependencies.
package dtq_pkg;

  localparam int MAX_EVENTS = 16;
  localparam int CNT_W      = $clog2(MAX_EVENTS + 1);

  localparam logic OP_ADD = 1'b0;
  localparam logic OP_INT = 1'b1;

  localparam logic [1:0] KIND_STATUS = 2'd0;
  localparam logic [1:0] KIND_FIRE   = 2'd1;
  localparam logic [1:0] KIND_PROG   = 2'd2;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic       load;
    logic       mul;
    logic       insert;
    logic       pop;
    logic       div_start;
    logic       emit;
    logic [1:0] emit_kind;
    logic       emit_last;
  } dtq_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic is_int;
    logic add_ok;
    logic ins_head;
    logic head_due;
    logic fsec_valid;
    logic out_free;
  } dtq_stat_t;

endpackage

FILE: rtl/dtq_if.sv
// Channel interfaces for the deadline timer queue (valid/ready transfer).
// Depends on nothing but plain logic widths.
interface dtq_in_if;
  logic        valid;
  logic        ready;
  logic        opcode;
  logic [31:0] seconds;
  logic [7:0]  tag;
  logic [63:0] now;
  modport source (output valid, opcode, seconds, tag, now, input ready);
  modport sink   (input valid, opcode, seconds, tag, now, output ready);
endinterface

interface dtq_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic        accepted;
  logic [7:0]  fired_tag;
  logic [63:0] fire_seconds;
  logic [63:0] next_delta;
  logic        timer_enable;
  logic        last;
  modport source (output valid, kind, accepted, fired_tag, fire_seconds, next_delta,
                  timer_enable, last, input ready);
  modport sink   (input valid, kind, accepted, fired_tag, fire_seconds, next_delta,
                  timer_enable, last, output ready);
endinterface

FILE: rtl/dtq_div.sv
// Iterative 64 by 32 bit restoring divider, one quotient bit per cycle.
// Standalone; used by dtq_dp.
module dtq_div (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [63:0] dividend,
  input  logic [31:0] divisor,
  output logic        done,
  output logic [63:0] quot
);
  logic        busy_r, busy_nxt;
  logic [6:0]  cnt_r, cnt_nxt;
  logic [31:0] rem_r, rem_nxt;
  logic [63:0] q_r, q_nxt;
  logic [31:0] dvs_r, dvs_nxt;
  logic        done_r, done_nxt;
  logic [32:0] rem_sh;
  logic [32:0] diff;

  // One restoring step
  always_comb begin
    rem_sh   = {rem_r, q_r[63]};
    diff     = rem_sh - {1'b0, dvs_r};
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    q_nxt    = q_r;
    dvs_nxt  = dvs_r;
    done_nxt = 1'b0;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = 7'd0;
      rem_nxt  = 32'd0;
      q_nxt    = dividend;
      dvs_nxt  = divisor;
    end else if (busy_r) begin
      if (!diff[32]) begin
        rem_nxt = diff[31:0];
        q_nxt   = {q_r[62:0], 1'b1};
      end else begin
        rem_nxt = rem_sh[31:0];
        q_nxt   = {q_r[62:0], 1'b0};
      end
      cnt_nxt = cnt_r + 7'd1;
      if (cnt_r == 7'd63) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= 7'd0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    q_r   <= q_nxt;
    dvs_r <= dvs_nxt;
  end

  assign done = done_r;
  assign quot = q_r;
endmodule

FILE: rtl/dtq_dp.sv
// Datapath: item registers, multiplier, sorted deadline row, divider and
// output register. Depends on dtq_pkg, dtq_if and dtq_div.
module dtq_dp (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [31:0]       cfg_wdata,
  dtq_in_if.sink            in_ch,
  dtq_out_if.source         out_ch,
  input  dtq_pkg::dtq_cmd_t cmd,
  output dtq_pkg::dtq_stat_t stat
);
  import dtq_pkg::*;

  logic [31:0] tps_r;
  logic        op_r;
  logic [31:0] sec_r;
  logic [7:0]  tag_r;
  logic [63:0] now_r;
  logic [63:0] dur_r;
  logic        ok_r;
  logic [63:0] fsec_r;
  logic        fsec_valid_r;

  logic [63:0] dl_r  [MAX_EVENTS];
  logic [7:0]  tg_r  [MAX_EVENTS];
  logic [CNT_W-1:0] cnt_r;

  logic [64:0] sum;
  logic        add_ok;
  logic [MAX_EVENTS-1:0] gt;
  logic        div_done;
  logic [63:0] div_q;

  logic        ov_r;
  logic [1:0]  o_kind_r;
  logic        o_acc_r;
  logic [7:0]  o_tag_r;
  logic [63:0] o_fsec_r;
  logic [63:0] o_delta_r;
  logic        o_en_r;
  logic        o_last_r;

  // Admission check and deadline
  assign sum    = {1'b0, now_r} + {1'b0, dur_r};
  assign add_ok = (sec_r != 32'd0) && (tps_r != 32'd0) &&
                  (cnt_r < CNT_W'(MAX_EVENTS)) && !sum[64];

  // Per-lane compare: later than the new deadline (ties go behind)
  always_comb begin
    for (int i = 0; i < MAX_EVENTS; i++)
      gt[i] = (CNT_W'(i) < cnt_r) && (dl_r[i] > sum[63:0]);
  end

  assign stat.is_int     = (op_r == OP_INT);
  assign stat.add_ok     = add_ok;
  assign stat.ins_head   = gt[0] || (cnt_r == '0);
  assign stat.head_due   = (cnt_r != '0) && (dl_r[0] <= now_r);
  assign stat.fsec_valid = fsec_valid_r;
  assign stat.out_free   = !ov_r || out_ch.ready;

  assign in_ch.ready = 1'b0 | cmd.load;

  dtq_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start && (tps_r != 32'd0)),
    .dividend (now_r),
    .divisor  (tps_r),
    .done     (div_done),
    .quot     (div_q)
  );

  // Configuration and item registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tps_r        <= 32'd0;
      fsec_valid_r <= 1'b0;
    end else begin
      if (cfg_we) tps_r <= cfg_wdata;
      if (cmd.load) fsec_valid_r <= 1'b0;
      else if (cmd.div_start && tps_r == 32'd0) fsec_valid_r <= 1'b1;
      else if (div_done) fsec_valid_r <= 1'b1;
    end
    if (cmd.load) begin
      op_r  <= in_ch.opcode;
      sec_r <= in_ch.seconds;
      tag_r <= in_ch.tag;
      now_r <= in_ch.now;
    end
    if (cmd.mul) dur_r <= 64'(sec_r) * 64'(tps_r);
    if (cmd.mul) ok_r <= 1'b0;
    else if (cmd.insert) ok_r <= 1'b1;
    if (cmd.div_start && tps_r == 32'd0) fsec_r <= 64'd0;
    else if (div_done) fsec_r <= div_q;
  end

  // Sorted row: insert shifts the later lanes up, pop shifts all down
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (cmd.insert) begin
      cnt_r <= cnt_r + CNT_W'(1);
    end else if (cmd.pop) begin
      cnt_r <= cnt_r - CNT_W'(1);
    end
    for (int i = 0; i < MAX_EVENTS; i++) begin
      if (cmd.insert) begin
        if (i > 0 && gt[(i > 0) ? i - 1 : 0]) begin
          dl_r[i] <= dl_r[(i > 0) ? i - 1 : 0];
          tg_r[i] <= tg_r[(i > 0) ? i - 1 : 0];
        end else if (gt[i] || CNT_W'(i) == cnt_r) begin
          dl_r[i] <= sum[63:0];
          tg_r[i] <= tag_r;
        end
      end else if (cmd.pop && i < MAX_EVENTS - 1) begin
        dl_r[i] <= dl_r[(i < MAX_EVENTS - 1) ? i + 1 : i];
        tg_r[i] <= tg_r[(i < MAX_EVENTS - 1) ? i + 1 : i];
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
    end else if (cmd.emit) begin
      ov_r <= 1'b1;
    end else if (out_ch.ready) begin
      ov_r <= 1'b0;
    end
    if (cmd.emit) begin
      o_kind_r  <= cmd.emit_kind;
      o_last_r  <= cmd.emit_last;
      o_acc_r   <= 1'b0;
      o_tag_r   <= 8'd0;
      o_fsec_r  <= 64'd0;
      o_delta_r <= 64'd0;
      o_en_r    <= 1'b0;
      unique case (cmd.emit_kind)
        KIND_STATUS: o_acc_r <= ok_r;
        KIND_FIRE: begin
          o_tag_r  <= tg_r[0];
          o_fsec_r <= fsec_r;
        end
        KIND_PROG: begin
          if (cnt_r != '0) begin
            o_en_r    <= 1'b1;
            o_delta_r <= dl_r[0] - now_r;
          end
        end
        default: o_acc_r <= 1'b0;
      endcase
    end
  end

  assign out_ch.valid        = ov_r;
  assign out_ch.kind         = o_kind_r;
  assign out_ch.accepted     = o_acc_r;
  assign out_ch.fired_tag    = o_tag_r;
  assign out_ch.fire_seconds = o_fsec_r;
  assign out_ch.next_delta   = o_delta_r;
  assign out_ch.timer_enable = o_en_r;
  assign out_ch.last         = o_last_r;
endmodule

FILE: rtl/dtq_ctrl.sv
// Controller state machine for the deadline timer queue.
// Depends on dtq_pkg.
module dtq_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  dtq_pkg::dtq_stat_t stat,
  output dtq_pkg::dtq_cmd_t  cmd
);
  import dtq_pkg::*;

  typedef enum logic [7:0] {
    S_IDLE  = 8'b00000001,
    S_MUL   = 8'b00000010,
    S_CHK   = 8'b00000100,
    S_DRAIN = 8'b00001000,
    S_DIV   = 8'b00010000,
    S_FIRE  = 8'b00100000,
    S_PROG  = 8'b01000000,
    S_STAT  = 8'b10000000
  } state_t;

  state_t state_r, state_nxt;

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        cmd.load = 1'b1;
        if (in_valid) state_nxt = S_MUL;
      end
      S_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = S_CHK;
      end
      S_CHK: begin
        if (stat.is_int) begin
          state_nxt = S_DRAIN;
        end else if (!stat.add_ok) begin
          state_nxt = S_STAT;
        end else begin
          cmd.insert = 1'b1;
          state_nxt  = stat.ins_head ? S_DRAIN : S_STAT;
        end
      end
      S_DRAIN: begin
        if (!stat.head_due) begin
          state_nxt = S_PROG;
        end else if (stat.fsec_valid) begin
          state_nxt = S_FIRE;
        end else begin
          cmd.div_start = 1'b1;
          state_nxt     = S_DIV;
        end
      end
      S_DIV: begin
        if (stat.fsec_valid) state_nxt = S_FIRE;
      end
      S_FIRE: begin
        if (stat.out_free) begin
          cmd.emit      = 1'b1;
          cmd.emit_kind = KIND_FIRE;
          cmd.pop       = 1'b1;
          state_nxt     = S_DRAIN;
        end
      end
      S_PROG: begin
        if (stat.out_free) begin
          cmd.emit      = 1'b1;
          cmd.emit_kind = KIND_PROG;
          cmd.emit_last = stat.is_int;
          state_nxt     = stat.is_int ? S_IDLE : S_STAT;
        end
      end
      S_STAT: begin
        if (stat.out_free) begin
          cmd.emit      = 1'b1;
          cmd.emit_kind = KIND_STATUS;
          cmd.emit_last = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else        state_r <= state_nxt;
  end
endmodule

FILE: rtl/deadline_timer_queue_core.sv
// Top level of the deadline timer queue: controller plus datapath.
// Depends on dtq_pkg, dtq_if, dtq_ctrl and dtq_dp.
//
// Holds up to 16 pending deadlines in a sorted row of registers (ties keep
// arrival order). An add computes now + seconds * ticks_per_second, inserts
// it and, if it became the head, drains due events and reprograms the timer;
// an interrupt drains and reprograms. Results leave through a registered
// output; the last result of an item carries last. After the transfer the
// item is multiplied, then checked, then each result is emitted in turn, and
// a drain adds one head check per expired event plus a final one. The first
// expiry of an item runs the serial divider for now / ticks_per_second, once
// per item; a stalled output holds the controller until it is free. One item
// is worked at a time; the input is ready again as soon as the last result
// sits in the output register.
module deadline_timer_queue_core (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      cfg_we,
  input  logic [31:0] cfg_wdata,
  dtq_in_if.sink    in_ch,
  dtq_out_if.source out_ch
);
  import dtq_pkg::*;

  dtq_cmd_t  cmd;
  dtq_stat_t stat;

  dtq_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .stat     (stat),
    .cmd      (cmd)
  );

  dtq_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cmd       (cmd),
    .stat      (stat)
  );
endmodule

FILE: tb/tb_deadline_timer_queue.sv
// Testbench for deadline_timer_queue_core: directed and random adds and
// interrupts, checked against an in-bench model of the sorted deadline queue.
// Depends on dtq_pkg, dtq_if and the core RTL.
`timescale 1ns / 1ps
module tb;
  import dtq_pkg::*;

  typedef struct packed {
    logic [1:0]  kind;
    logic        accepted;
    logic [7:0]  fired_tag;
    logic [63:0] fire_seconds;
    logic [63:0] next_delta;
    logic        timer_enable;
    logic        last;
  } dtq_res_t;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [31:0] cfg_wdata;

  dtq_in_if  in_ch ();
  dtq_out_if out_ch ();

  deadline_timer_queue_core u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .in_ch    (in_ch.sink),
    .out_ch   (out_ch.source)
  );

  // Model state
  logic [63:0] q_deadline [MAX_EVENTS];
  logic [7:0]  q_tag [MAX_EVENTS];
  int          q_count;
  logic [31:0] tick_rate;

  dtq_res_t expected_results [$];
  int       fail_count;
  longint   cycle_count;
  int       hold_off;
  logic [63:0] clock_now;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Run limit
  initial begin
    cycle_count = 0;
    forever begin
      @(posedge clk);
      cycle_count++;
      if (cycle_count > 400000) begin
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  function automatic dtq_res_t mk_res(logic [1:0] k, logic acc, logic [7:0] ft,
                                      logic [63:0] fs, logic [63:0] nd, logic en);
    dtq_res_t r;
    r.kind = k; r.accepted = acc; r.fired_tag = ft; r.fire_seconds = fs;
    r.next_delta = nd; r.timer_enable = en; r.last = 1'b0;
    return r;
  endfunction

  // Pop due events and reprogram the timer
  task automatic drain_due(input logic [63:0] now, ref dtq_res_t res[$]);
    logic [63:0] fsec;
    while (q_count > 0 && q_deadline[0] <= now) begin
      fsec = (tick_rate != 0) ? now / {32'd0, tick_rate} : 64'd0;
      res.push_back(mk_res(KIND_FIRE, 1'b0, q_tag[0], fsec, 64'd0, 1'b0));
      for (int i = 1; i < q_count; i++) begin
        q_deadline[i-1] = q_deadline[i];
        q_tag[i-1] = q_tag[i];
      end
      q_count--;
    end
    if (q_count == 0)
      res.push_back(mk_res(KIND_PROG, 1'b0, 8'd0, 64'd0, 64'd0, 1'b0));
    else
      res.push_back(mk_res(KIND_PROG, 1'b0, 8'd0, 64'd0, q_deadline[0] - now, 1'b1));
  endtask

  task automatic predict_queue(input logic op, input logic [31:0] secs,
                               input logic [7:0] tg, input logic [63:0] now);
    dtq_res_t res [$];
    logic [63:0] dur, dl;
    logic ok;
    int pos;
    if (op == OP_INT) begin
      drain_due(now, res);
    end else begin
      ok = 1'b1;
      dur = 64'd0;
      pos = 0;
      if (secs == 0 || tick_rate == 0 || q_count >= MAX_EVENTS) begin
        ok = 1'b0;
      end else begin
        dur = {32'd0, secs} * {32'd0, tick_rate};
        if (64'hFFFF_FFFF_FFFF_FFFF - now < dur) ok = 1'b0;
      end
      if (ok) begin
        dl = now + dur;
        while (pos < q_count && q_deadline[pos] <= dl) pos++;
        for (int i = q_count; i > pos; i--) begin
          q_deadline[i] = q_deadline[i-1];
          q_tag[i] = q_tag[i-1];
        end
        q_deadline[pos] = dl;
        q_tag[pos] = tg;
        q_count++;
        if (pos == 0) drain_due(now, res);
      end
      res.push_back(mk_res(KIND_STATUS, ok, 8'd0, 64'd0, 64'd0, 1'b0));
    end
    res[res.size()-1].last = 1'b1;
    foreach (res[i]) expected_results.push_back(res[i]);
  endtask

  // Send one item: random gap with valid low, then hold valid until the
  // transfer; valid stays up so a zero gap follows straight on
  task automatic send_item(input logic op, input logic [31:0] secs,
                           input logic [7:0] tg, input logic [63:0] now);
    int gap;
    gap = $urandom_range(0, 12);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.opcode  <= op;
    in_ch.seconds <= secs;
    in_ch.tag     <= tg;
    in_ch.now     <= now;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    predict_queue(op, secs, tg, now);
  endtask

  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (120) @(posedge clk);
  endtask

  task automatic write_rate(input logic [31:0] v);
    wait_idle();
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    tick_rate = v;
  endtask

  // Receiver: random stalls, plus a long hold-off on request
  initial begin
    int stall;
    out_ch.ready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      if (hold_off > 0) begin
        hold_off--;
        out_ch.ready <= 1'b0;
      end else begin
        stall = $urandom_range(0, 12);
        if ($urandom_range(0, 3) == 0 && stall > 0) begin
          out_ch.ready <= 1'b0;
          repeat (stall) @(posedge clk);
        end
        out_ch.ready <= 1'b1;
      end
    end
  end

  // Result checker
  initial begin
    dtq_res_t exp_r;
    forever begin
      @(posedge clk);
      if (rst_n && out_ch.valid && out_ch.ready) begin
        if (expected_results.size() == 0) begin
          $error("unexpected result transfer");
          fail_count++;
        end else begin
          exp_r = expected_results.pop_front();
          if (out_ch.kind !== exp_r.kind) begin
            $error("kind exp %0d got %0d", exp_r.kind, out_ch.kind); fail_count++;
          end
          if (out_ch.accepted !== exp_r.accepted) begin
            $error("accepted exp %0d got %0d", exp_r.accepted, out_ch.accepted);
            fail_count++;
          end
          if (out_ch.fired_tag !== exp_r.fired_tag) begin
            $error("fired_tag exp %0d got %0d", exp_r.fired_tag, out_ch.fired_tag);
            fail_count++;
          end
          if (out_ch.fire_seconds !== exp_r.fire_seconds) begin
            $error("fire_seconds exp %0d got %0d", exp_r.fire_seconds,
                   out_ch.fire_seconds);
            fail_count++;
          end
          if (out_ch.next_delta !== exp_r.next_delta) begin
            $error("next_delta exp %0d got %0d", exp_r.next_delta, out_ch.next_delta);
            fail_count++;
          end
          if (out_ch.timer_enable !== exp_r.timer_enable) begin
            $error("timer_enable exp %0d got %0d", exp_r.timer_enable,
                   out_ch.timer_enable);
            fail_count++;
          end
          if (out_ch.last !== exp_r.last) begin
            $error("last exp %0d got %0d", exp_r.last, out_ch.last); fail_count++;
          end
        end
      end
    end
  end

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  // Directed: extremes, rejects, ties, overflow, full store
  task automatic test_directed();
    write_rate(32'd0);
    send_item(OP_ADD, 32'd5, 8'hFF, 64'd0);                // zero rate rejects
    send_item(OP_INT, 32'd0, 8'd0, 64'd0);                  // empty interrupt
    write_rate(32'hFFFF_FFFF);
    send_item(OP_ADD, 32'hFFFF_FFFF, 8'h00, 64'd0);         // largest product
    send_item(OP_ADD, 32'd1, 8'h01, 64'hFFFF_FFFF_FFFF_FFFF); // overflow
    send_item(OP_ADD, 32'd0, 8'h02, 64'd0);                 // zero seconds
    send_item(OP_INT, 32'hFFFF_FFFF, 8'hFF, 64'hFFFF_FFFF_FFFF_FFFF);
    write_rate(32'd1);
    // equal deadlines keep order, then fill past capacity
    for (int i = 0; i < MAX_EVENTS + 2; i++)
      send_item(OP_ADD, 32'd10, i[7:0], 64'd100);
    send_item(OP_INT, 32'd0, 8'd0, 64'd109);                // nothing due yet
    send_item(OP_INT, 32'd0, 8'd0, 64'd110);                // all fire
    send_item(OP_ADD, 32'd3, 8'hA5, 64'd200);
    write_rate(32'd0);
    send_item(OP_INT, 32'd0, 8'd0, 64'd300);                // fire with zero rate
  endtask

  // Random mostly well-formed traffic on an advancing clock
  task automatic test_random(input int n_items);
    logic [63:0] step;
    for (int i = 0; i < n_items; i++) begin
      if (i % 60 == 0) begin
        case ($urandom_range(0, 3))
          0: write_rate(32'd1);
          1: write_rate($urandom_range(1, 1000));
          2: write_rate($urandom());
          default: write_rate(32'hFFFF_FFFF);
        endcase
        clock_now = (tick_rate > 1000) ? {32'd0, $urandom()} : rand64() >> 1;
      end
      step = $urandom_range(0, 4) * {32'd0, tick_rate};
      clock_now = clock_now + step;
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4:
          send_item(OP_ADD, $urandom_range(1, 5), 8'($urandom()), clock_now);
        5, 6, 7:
          send_item(OP_INT, $urandom(), 8'($urandom()), clock_now);
        8:
          send_item(1'($urandom_range(0, 1)), $urandom(), 8'($urandom()), rand64());
        default:
          send_item(OP_ADD, $urandom(), 8'($urandom()), clock_now);
      endcase
    end
  endtask

  // Long receiver stall while the sender keeps offering
  task automatic test_backpressure();
    write_rate(32'd2);
    hold_off = 400;
    for (int i = 0; i < 20; i++)
      send_item(OP_ADD, 32'd1, i[7:0], 64'd1000);
    send_item(OP_INT, 32'd0, 8'd0, 64'd1002);
  endtask

  initial begin
    fail_count    = 0;
    hold_off      = 0;
    q_count       = 0;
    tick_rate     = 32'd0;
    clock_now     = 64'd0;
    rst_n         = 1'b0;
    cfg_we        = 1'b0;
    cfg_wdata     = 32'd0;
    in_ch.valid   = 1'b0;
    in_ch.opcode  = OP_ADD;
    in_ch.seconds = 32'd0;
    in_ch.tag     = 8'd0;
    in_ch.now     = 64'd0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_backpressure();
    test_random(200);
    wait_idle();
    if (fail_count == 0 && expected_results.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
